FILE: design/mcsm_pkg.sv
// Shared types, constants and command codes of the clip sequencer mixer.
package mcsm_pkg;

	localparam int CHANNELS = 4;
	localparam int STORE_BYTES = 65536;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int MASK_W = 4;

	typedef enum logic [3:0] {
		OP_TICK        = 4'd0,
		OP_PLAY        = 4'd1,
		OP_LOOP        = 4'd2,
		OP_PLAY_NEXT   = 4'd3,
		OP_LOOP_NEXT   = 4'd4,
		OP_TRANSITION  = 4'd5,
		OP_STOP        = 4'd6,
		OP_STOP_ALL    = 4'd7,
		OP_STORE_WRITE = 4'd8
	} op_t;

	localparam logic [0:0] REG_SAMPLE_8BIT = 1'd0;

	typedef struct packed {
		logic [3:0]  func;
		logic [1:0]  channel;
		logic [15:0] clip_start;
		logic [16:0] clip_length;
		logic [15:0] store_address;
		logic [7:0]  store_byte;
	} cmd_t;

	typedef struct packed {
		logic        is_sample;
		logic [15:0] mixed_sample;
		logic [3:0]  done_mask;
		logic [3:0]  active_mask;
		logic        amp_enable;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic          capture;   // latch command, write the store
		logic          tick_clr;  // clear accumulator
		logic          rd_lo;     // issue low byte read
		logic          rd_hi;     // issue high byte read
		logic          ch_step;   // finish current channel
		logic [CH_W-1:0] ch;
		logic          finish;    // run channel commands
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic ch_play;   // selected channel plays and has a whole sample
		logic sample_8;
	} dp_stat_t;

endpackage

FILE: design/mcsm_if.sv
// Valid/ready channel interfaces for commands and results.
interface mcsm_cmd_if (input logic clk);
	logic valid;
	logic ready;
	mcsm_pkg::cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mcsm_res_if (input logic clk);
	logic valid;
	logic ready;
	mcsm_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/mcsm_ram.sv
// Generic single-port RAM with registered read.
module mcsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

FILE: design/mcsm_datapath.sv
// Channel clip state, sample store and saturating mix accumulator.
module mcsm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mcsm_pkg::cmd_t      cmd,
	input  mcsm_pkg::dp_cmd_t   ctl,
	input  logic                sample_8bit,
	output mcsm_pkg::dp_stat_t  stat,
	output mcsm_pkg::res_t      res
);
	localparam int C = mcsm_pkg::CHANNELS;
	localparam int AW = mcsm_pkg::ADDR_W;

	logic [C-1:0]  playing_q, next_valid_q, next_loops_q, loop_valid_q;
	logic [15:0]   cur_start_q [C];
	logic [16:0]   cur_length_q [C];
	logic [16:0]   cur_offset_q [C];
	logic [15:0]   next_start_q [C];
	logic [16:0]   next_length_q [C];
	logic [15:0]   loop_start_q [C];
	logic [16:0]   loop_length_q [C];
	logic          amp_q;
	mcsm_pkg::cmd_t cmd_q;
	logic signed [19:0] acc_q;
	logic [7:0]    lo_q;
	logic [C-1:0]  done_q;
	logic          ch_ok;

	// ram port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_rdata;
	logic [16:0]   rem, bps, rem_after;
	logic [16:0]   base_addr;
	logic signed [19:0] smp;

	assign ch_ok = ({30'd0, cmd_q.channel} < C);
	assign bps = sample_8bit ? 17'd1 : 17'd2;
	assign rem = (cur_length_q[ctl.ch] > cur_offset_q[ctl.ch]) ?
		cur_length_q[ctl.ch] - cur_offset_q[ctl.ch] : 17'd0;
	assign base_addr = {1'b0, cur_start_q[ctl.ch]} + cur_offset_q[ctl.ch];

	// status: tick flag, channel has a whole sample, sample format
	assign stat = {(cmd_q.func == mcsm_pkg::OP_TICK),
		(playing_q[ctl.ch] && (rem >= bps)), sample_8bit};

	// store access: command writes, tick reads
	always_comb begin
		ram_we = ctl.capture && (cmd.func == mcsm_pkg::OP_STORE_WRITE);
		ram_re = ctl.rd_lo || ctl.rd_hi;
		if (ram_we) begin
			ram_addr = cmd.store_address[AW-1:0];
		end else if (ctl.rd_hi) begin
			ram_addr = base_addr[AW-1:0] + AW'(1);
		end else begin
			ram_addr = base_addr[AW-1:0];
		end
	end

	mcsm_ram #(.WIDTH(8), .DEPTH(mcsm_pkg::STORE_BYTES)) u_store (
		.clk(clk), .we(ram_we), .re(ram_re), .addr(ram_addr),
		.wdata(cmd.store_byte), .rdata(ram_rdata)
	);

	// sample value for the step of the current channel
	always_comb begin
		if (sample_8bit) begin
			smp = 20'(($signed({12'd0, ram_rdata}) - 20'sd128) * 20'sd256);
		end else begin
			smp = 20'($signed({ram_rdata, lo_q}));
		end
	end

	assign rem_after = (rem >= bps) ? rem - bps : rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= '0;
			next_valid_q <= '0;
			next_loops_q <= '0;
			loop_valid_q <= '0;
			amp_q <= 1'b0;
			done_q <= '0;
			acc_q <= '0;
			cmd_q <= '0;
			lo_q <= '0;
			for (int i = 0; i < C; i++) begin
				cur_start_q[i] <= '0;
				cur_length_q[i] <= '0;
				cur_offset_q[i] <= '0;
				next_start_q[i] <= '0;
				next_length_q[i] <= '0;
				loop_start_q[i] <= '0;
				loop_length_q[i] <= '0;
			end
		end else begin
			if (ctl.capture) begin
				cmd_q <= cmd;
				done_q <= '0;
			end
			if (ctl.tick_clr) begin
				acc_q <= '0;
				done_q <= '0;
			end
			// the low byte of a 16-bit sample, read by rd_lo, is captured while rd_hi is issued
			if (ctl.rd_hi) begin
				lo_q <= ram_rdata;
			end
			// one channel step: mix, advance, sequence
			if (ctl.ch_step && playing_q[ctl.ch]) begin
				if (rem >= bps) begin
					acc_q <= acc_q + smp;
					cur_offset_q[ctl.ch] <= cur_offset_q[ctl.ch] + bps;
				end
				if (rem_after < bps) begin
					if (next_valid_q[ctl.ch]) begin
						cur_start_q[ctl.ch] <= next_start_q[ctl.ch];
						cur_length_q[ctl.ch] <= next_length_q[ctl.ch];
						cur_offset_q[ctl.ch] <= '0;
						if (next_loops_q[ctl.ch]) begin
							loop_valid_q[ctl.ch] <= 1'b1;
							loop_start_q[ctl.ch] <= next_start_q[ctl.ch];
							loop_length_q[ctl.ch] <= next_length_q[ctl.ch];
						end
						next_valid_q[ctl.ch] <= 1'b0;
						next_loops_q[ctl.ch] <= 1'b0;
						next_start_q[ctl.ch] <= '0;
						next_length_q[ctl.ch] <= '0;
					end else if (loop_valid_q[ctl.ch]) begin
						cur_start_q[ctl.ch] <= loop_start_q[ctl.ch];
						cur_length_q[ctl.ch] <= loop_length_q[ctl.ch];
						cur_offset_q[ctl.ch] <= '0;
					end else begin
						playing_q[ctl.ch] <= 1'b0;
						done_q[ctl.ch] <= 1'b1;
					end
				end
			end
			// channel commands run in the finish cycle
			if (ctl.finish && ch_ok) begin
				case (cmd_q.func)
					mcsm_pkg::OP_PLAY, mcsm_pkg::OP_LOOP: begin
						cur_start_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= cmd_q.clip_start;
						cur_length_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= cmd_q.clip_length;
						cur_offset_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= '0;
						playing_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= 1'b1;
						next_valid_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <=
							(cmd_q.func == mcsm_pkg::OP_LOOP) &&
							next_valid_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]];
						loop_valid_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <=
							(cmd_q.func == mcsm_pkg::OP_LOOP);
						loop_start_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <=
							(cmd_q.func == mcsm_pkg::OP_LOOP) ? cmd_q.clip_start : 16'd0;
						loop_length_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <=
							(cmd_q.func == mcsm_pkg::OP_LOOP) ? cmd_q.clip_length : 17'd0;
						if (cmd_q.func == mcsm_pkg::OP_PLAY) begin
							next_loops_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= 1'b0;
							next_start_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= '0;
							next_length_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= '0;
						end
					end
					mcsm_pkg::OP_PLAY_NEXT, mcsm_pkg::OP_LOOP_NEXT,
					mcsm_pkg::OP_TRANSITION: begin
						next_valid_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= 1'b1;
						next_start_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= cmd_q.clip_start;
						next_length_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= cmd_q.clip_length;
						next_loops_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <=
							(cmd_q.func == mcsm_pkg::OP_LOOP_NEXT);
						if (cmd_q.func == mcsm_pkg::OP_TRANSITION) begin
							loop_valid_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= 1'b0;
							loop_start_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= '0;
							loop_length_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= '0;
						end
					end
					mcsm_pkg::OP_STOP: begin
						playing_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= 1'b0;
						next_valid_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= 1'b0;
						next_loops_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= 1'b0;
						next_start_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= '0;
						next_length_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= '0;
						loop_valid_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= 1'b0;
						loop_start_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= '0;
						loop_length_q[cmd_q.channel[mcsm_pkg::CH_W-1:0]] <= '0;
					end
					default: begin
					end
				endcase
			end
			if (ctl.finish && (cmd_q.func == mcsm_pkg::OP_STOP_ALL)) begin
				playing_q <= '0;
				next_valid_q <= '0;
				next_loops_q <= '0;
				loop_valid_q <= '0;
				for (int i = 0; i < C; i++) begin
					next_start_q[i] <= '0;
					next_length_q[i] <= '0;
					loop_start_q[i] <= '0;
					loop_length_q[i] <= '0;
				end
			end
			if (ctl.finish && ch_ok &&
			    (cmd_q.func == mcsm_pkg::OP_PLAY || cmd_q.func == mcsm_pkg::OP_LOOP)) begin
				amp_q <= 1'b1;
			end
		end
	end

	// result fields from state after the item
	logic [C-1:0] act_now;
	assign act_now = playing_q;

	always_comb begin
		logic [7:0] am, dm;
		am = 8'(act_now);
		dm = 8'(done_q);
		res.is_sample = stat.is_tick;
		if (!stat.is_tick) begin
			res.mixed_sample = '0;
		end else if (acc_q > 20'sd32767) begin
			res.mixed_sample = 16'h7fff;
		end else if (acc_q < -20'sd32768) begin
			res.mixed_sample = 16'h8000;
		end else begin
			res.mixed_sample = acc_q[15:0];
		end
		res.done_mask = stat.is_tick ? dm[3:0] : 4'd0;
		res.active_mask = am[3:0];
		res.amp_enable = amp_q && (act_now != '0);
	end

	// after stop-all no channel may play or keep a queued clip
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctl.finish) && $past(cmd_q.func) == mcsm_pkg::OP_STOP_ALL |->
		playing_q == '0 && next_valid_q == '0)
		else $error("stop_all left state");
	// a channel that ends cannot still be playing
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q & playing_q) == '0 || $past(ctl.finish))
		else $error("done channel still playing");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_hi |-> !ram_we)
		else $error("store write collides with read");
endmodule

FILE: design/mcsm_ctrl.sv
// Sequencer that steps the datapath through one item at a time.
module mcsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mcsm_pkg::dp_stat_t  stat,
	output mcsm_pkg::dp_cmd_t   ctl
);
	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_CH, S_RD2, S_STEP, S_FINISH, S_OUT
	} state_t;

	state_t state_q;
	logic [mcsm_pkg::CH_W-1:0] ch_q;
	logic                      last_ch;

	assign last_ch = (32'(ch_q) == mcsm_pkg::CHANNELS - 1);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		ctl = '0;
		ctl.ch = ch_q;
		ctl.capture = in_valid && in_ready;
		ctl.tick_clr = (state_q == S_DISPATCH);
		ctl.rd_lo = (state_q == S_CH) && stat.ch_play;
		ctl.rd_hi = (state_q == S_RD2);
		ctl.ch_step = (state_q == S_STEP);
		ctl.finish = (state_q == S_FINISH);
	end

	// per channel: read low (and high) byte, then step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					ch_q <= '0;
					state_q <= stat.is_tick ? S_CH : S_FINISH;
				end
				S_CH: begin
					if (stat.ch_play && !stat.sample_8) state_q <= S_RD2;
					else state_q <= S_STEP;
				end
				S_RD2: state_q <= S_STEP;
				S_STEP: begin
					if (last_ch) begin
						state_q <= S_FINISH;
					end else begin
						ch_q <= ch_q + 1'b1;
						state_q <= S_CH;
					end
				end
				S_FINISH: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("overlap of items");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_hi |=> ctl.ch_step)
		else $error("high read not followed by step");
endmodule

FILE: design/multichannel_clip_sequencer_mixer_core.sv
// Top level of the multichannel clip sequencer and saturating mixer.
//
// Commands enter on cmd (valid/ready); one result leaves on res for each
// command. A tick mixes every playing channel from the sample store and
// advances its clip; other commands edit channel state or the store.
// One item at a time is in flight. A tick visits the channels one by
// one through the one store read port. The next command is taken in
// the cycle after the result transfers.
// The result waits in place while the receiver stalls; no command is
// taken until it has gone. Reset clears all channel state and the
// register; the store contents are undefined until written.
// Register 0 (sample_8bit) lies at byte address 0. The user must write
// it only while the block is idle; the block does not enforce this.
module multichannel_clip_sequencer_mixer_core (
	input  logic        clk,
	input  logic        arst_n,
	mcsm_cmd_if.sink    cmd,
	mcsm_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic              sample_8bit_q;
	mcsm_pkg::dp_cmd_t ctl;
	mcsm_pkg::dp_stat_t stat;

	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == 2'd0) ? {31'd0, sample_8bit_q} : 32'd0;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_8bit_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			sample_8bit_q <= pwdata[0];
		end
	end

	mcsm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cmd.valid), .in_ready(cmd.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.stat(stat), .ctl(ctl)
	);

	mcsm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.data), .ctl(ctl),
		.sample_8bit(sample_8bit_q), .stat(stat), .res(res.data)
	);
endmodule

FILE: bench/mcsm_checker.sv
// Scoreboard for the clip sequencer mixer: predicts each result and compares it.
`timescale 1ns / 100ps

module mcsm_checker (
	input  logic        clk,
	input  logic        arst_n,
	mcsm_cmd_if         cmd,
	mcsm_res_if         res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);

	// mixer state mirror
	logic [7:0]  store_mem [mcsm_pkg::STORE_BYTES];
	logic        playing [mcsm_pkg::CHANNELS];
	logic [15:0] cur_start [mcsm_pkg::CHANNELS];
	logic [16:0] cur_length [mcsm_pkg::CHANNELS];
	logic [16:0] cur_offset [mcsm_pkg::CHANNELS];
	logic        next_valid [mcsm_pkg::CHANNELS];
	logic [15:0] next_start [mcsm_pkg::CHANNELS];
	logic [16:0] next_length [mcsm_pkg::CHANNELS];
	logic        next_loops [mcsm_pkg::CHANNELS];
	logic        loop_valid [mcsm_pkg::CHANNELS];
	logic [15:0] loop_start [mcsm_pkg::CHANNELS];
	logic [16:0] loop_length [mcsm_pkg::CHANNELS];
	logic        amp_on;
	logic        mode_8bit;

	mcsm_pkg::res_t results_due [$];

	function automatic logic [16:0] left_in_clip(int ch);
		return (cur_length[ch] > cur_offset[ch]) ? cur_length[ch] - cur_offset[ch] : '0;
	endfunction

	function automatic void drop_channel(int ch);
		loop_valid[ch] = 0;
		loop_start[ch] = '0;
		loop_length[ch] = '0;
		next_valid[ch] = 0;
		next_start[ch] = '0;
		next_length[ch] = '0;
		next_loops[ch] = 0;
		playing[ch] = 0;
	endfunction

	function automatic void clear_next(int ch);
		next_valid[ch] = 0;
		next_start[ch] = '0;
		next_length[ch] = '0;
		next_loops[ch] = 0;
	endfunction

	function automatic void clear_loop_clip(int ch);
		loop_valid[ch] = 0;
		loop_start[ch] = '0;
		loop_length[ch] = '0;
	endfunction

	function automatic void launch_clip(int ch, logic [15:0] s, logic [16:0] l);
		cur_start[ch] = s;
		cur_length[ch] = l;
		cur_offset[ch] = '0;
		playing[ch] = 1;
		amp_on = 1;
	endfunction

	// mix one channel; returns 1 when the channel ran out with nothing to follow
	function automatic bit advance_channel(int ch, inout int mix);
		logic [16:0] step;
		logic [15:0] addr;
		step = mode_8bit ? 17'd1 : 17'd2;
		if (left_in_clip(ch) >= step) begin
			addr = cur_start[ch] + cur_offset[ch][15:0];
			if (mode_8bit)
				mix += (int'(store_mem[addr]) - 128) * 256;
			else
				mix += int'($signed({store_mem[16'(addr + 16'd1)], store_mem[addr]}));
			cur_offset[ch] = cur_offset[ch] + step;
		end
		if (left_in_clip(ch) >= step)
			return 0;
		if (next_valid[ch]) begin
			cur_start[ch] = next_start[ch];
			cur_length[ch] = next_length[ch];
			cur_offset[ch] = '0;
			if (next_loops[ch]) begin
				loop_valid[ch] = 1;
				loop_start[ch] = next_start[ch];
				loop_length[ch] = next_length[ch];
			end
			clear_next(ch);
			return 0;
		end
		if (loop_valid[ch]) begin
			cur_start[ch] = loop_start[ch];
			cur_length[ch] = loop_length[ch];
			cur_offset[ch] = '0;
			return 0;
		end
		playing[ch] = 0;
		return 1;
	endfunction

	function automatic mcsm_pkg::res_t mix_command(mcsm_pkg::cmd_t c);
		mcsm_pkg::res_t r;
		int mix;
		logic [3:0] done;
		logic [3:0] active;
		int ch;
		mix = 0;
		done = '0;
		active = '0;
		ch = c.channel;
		case (c.func)
			mcsm_pkg::OP_TICK: begin
				for (int i = 0; i < mcsm_pkg::CHANNELS; i++)
					if (playing[i] && advance_channel(i, mix))
						done[i] = 1'b1;
				if (mix > 32767) mix = 32767;
				if (mix < -32768) mix = -32768;
			end
			mcsm_pkg::OP_PLAY: begin
				clear_loop_clip(ch);
				clear_next(ch);
				launch_clip(ch, c.clip_start, c.clip_length);
			end
			mcsm_pkg::OP_LOOP: begin
				loop_valid[ch] = 1;
				loop_start[ch] = c.clip_start;
				loop_length[ch] = c.clip_length;
				launch_clip(ch, c.clip_start, c.clip_length);
			end
			mcsm_pkg::OP_PLAY_NEXT, mcsm_pkg::OP_LOOP_NEXT: begin
				next_valid[ch] = 1;
				next_start[ch] = c.clip_start;
				next_length[ch] = c.clip_length;
				next_loops[ch] = (c.func == mcsm_pkg::OP_LOOP_NEXT);
			end
			mcsm_pkg::OP_TRANSITION: begin
				clear_loop_clip(ch);
				next_valid[ch] = 1;
				next_start[ch] = c.clip_start;
				next_length[ch] = c.clip_length;
				next_loops[ch] = 0;
			end
			mcsm_pkg::OP_STOP: drop_channel(ch);
			mcsm_pkg::OP_STOP_ALL:
				for (int i = 0; i < mcsm_pkg::CHANNELS; i++) drop_channel(i);
			mcsm_pkg::OP_STORE_WRITE: store_mem[c.store_address] = c.store_byte;
			default: ;
		endcase
		for (int i = 0; i < mcsm_pkg::CHANNELS && i < 4; i++)
			active[i] = playing[i];
		if (active == '0)
			amp_on = 0;
		r.is_sample = (c.func == mcsm_pkg::OP_TICK);
		r.mixed_sample = 16'(mix);
		r.done_mask = done;
		r.active_mask = active;
		r.amp_enable = amp_on;
		return r;
	endfunction

	// compare results, then predict new commands and track the register
	always @(posedge clk or negedge arst_n) begin
		mcsm_pkg::res_t want;
		if (!arst_n) begin
			for (int i = 0; i < mcsm_pkg::CHANNELS; i++) begin
				drop_channel(i);
				cur_start[i] = '0;
				cur_length[i] = '0;
				cur_offset[i] = '0;
			end
			amp_on = 0;
			mode_8bit = 0;
			results_due.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (results_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result %p", $realtime, res.data);
				end else begin
					want = results_due.pop_front();
					if (res.data !== want) begin
						fails++;
						if (fails <= 10)
							$display("%0t: result mismatch: expected %p, got %p",
								$realtime, want, res.data);
					end
				end
			end
			if (cmd.valid && cmd.ready)
				results_due.push_back(mix_command(cmd.data));
			if (psel && penable && pwrite && pready &&
			    paddr == 2'(4 * mcsm_pkg::REG_SAMPLE_8BIT))
				mode_8bit = pwdata[0];
			pending = results_due.size();
		end
	end

endmodule

FILE: bench/tb.sv
// Testbench top: drives commands, register writes and result stalls, reports the verdict.
`timescale 1ns / 100ps

module tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        took;
	int          fails;
	int          pending;
	int          stall_left;

	mcsm_cmd_if cmd (clk);
	mcsm_res_if res (clk);

	multichannel_clip_sequencer_mixer_core u_top (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mcsm_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .fails(fails), .pending(pending)
	);

	always #5 clk = ~clk;

	// flag a command transfer for the driver to see at the next falling edge
	always @(posedge clk) took <= cmd.valid && cmd.ready;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// stall the result side in random stretches
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res.ready = 0;
		end else begin
			res.ready = 1;
			if ($urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	task automatic send(mcsm_pkg::cmd_t c);
		int g;
		g = gap_len();
		if (g > 0) begin
			cmd.valid = 0;
			repeat (g) @(negedge clk);
		end
		cmd.data = c;
		cmd.valid = 1;
		do begin
			@(posedge clk);
			@(negedge clk);
		end while (!took);
		cmd.valid = 0;
	endtask

	function automatic mcsm_pkg::cmd_t make_cmd(mcsm_pkg::op_t f, int ch, int s, int l);
		mcsm_pkg::cmd_t c;
		c = '{default: '0};
		c.func = f;
		c.channel = 2'(ch);
		c.clip_start = 16'(s);
		c.clip_length = 17'(l);
		c.store_address = 16'($urandom);
		c.store_byte = 8'($urandom);
		return c;
	endfunction

	task automatic poke_store(int a, int b);
		mcsm_pkg::cmd_t c;
		c = make_cmd(mcsm_pkg::OP_STORE_WRITE, $urandom_range(0, 3), $urandom, $urandom);
		c.store_address = 16'(a);
		c.store_byte = 8'(b);
		send(c);
	endtask

	task automatic write_mode(logic m);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		psel = 1;
		pwrite = 1;
		paddr = 2'(4 * mcsm_pkg::REG_SAMPLE_8BIT);
		pwdata = {$urandom} & 32'hFFFF_FFFE | 32'(m);
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic tick();
		send(make_cmd(mcsm_pkg::OP_TICK, $urandom_range(0, 3), $urandom, $urandom));
	endtask

	// random clip inside the written part of the store
	function automatic mcsm_pkg::cmd_t random_clip(mcsm_pkg::op_t f);
		int s, l, r;
		r = $urandom_range(0, 99);
		s = (r < 85) ? $urandom_range(0, 400) : 65528 + $urandom_range(0, 7);
		r = $urandom_range(0, 99);
		l = (r < 70) ? $urandom_range(0, 40) : (r < 90) ? $urandom_range(0, 3)
			: $urandom_range(40, 100);
		return make_cmd(f, $urandom_range(0, 3), s, l);
	endfunction

	task automatic random_items(int n);
		int r;
		mcsm_pkg::cmd_t c;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				c = make_cmd(mcsm_pkg::OP_TICK, $urandom_range(0, 3), $urandom, $urandom);
			else if (r < 55) c = random_clip(mcsm_pkg::OP_PLAY);
			else if (r < 63) c = random_clip(mcsm_pkg::OP_LOOP);
			else if (r < 71) c = random_clip(mcsm_pkg::OP_PLAY_NEXT);
			else if (r < 78) c = random_clip(mcsm_pkg::OP_LOOP_NEXT);
			else if (r < 84) c = random_clip(mcsm_pkg::OP_TRANSITION);
			else if (r < 89)
				c = make_cmd(mcsm_pkg::OP_STOP, $urandom_range(0, 3), $urandom, $urandom);
			else if (r < 91)
				c = make_cmd(mcsm_pkg::OP_STOP_ALL, $urandom_range(0, 3), $urandom, $urandom);
			else if (r < 96) c = make_cmd(mcsm_pkg::OP_STORE_WRITE, 0, $urandom, $urandom);
			else begin
				c = make_cmd(mcsm_pkg::OP_TICK, $urandom_range(0, 3), $urandom, $urandom);
				c.func = 4'($urandom_range(9, 15));
			end
			send(c);
		end
	endtask

	initial begin
		cmd.valid = 0;
		cmd.data = '0;
		res.ready = 0;
		stall_left = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// fill: loud patterns first so mixes saturate, then random bytes
		for (int a = 0; a < 512; a++)
			if (a < 128) poke_store(a, a[0] ? 8'h7F : 8'hFF);
			else if (a < 256) poke_store(a, a[0] ? 8'h80 : 8'h00);
			else poke_store(a, $urandom);
		for (int a = 65528; a < 65536; a++)
			poke_store(a, $urandom);

		// directed cases in 16-bit mode
		send(make_cmd(mcsm_pkg::OP_PLAY, 0, 0, 8));
		send(make_cmd(mcsm_pkg::OP_LOOP, 1, 2, 5));
		send(make_cmd(mcsm_pkg::OP_PLAY, 2, 300, 0));
		send(make_cmd(mcsm_pkg::OP_LOOP, 3, 4, 6));
		tick();
		send(make_cmd(mcsm_pkg::OP_PLAY_NEXT, 0, 128, 4));
		send(make_cmd(mcsm_pkg::OP_LOOP_NEXT, 2, 65534, 6));
		send(make_cmd(mcsm_pkg::OP_TRANSITION, 1, 200, 3));
		repeat (5) tick();
		send(make_cmd(mcsm_pkg::OP_STOP, 2, 0, 0));
		send(make_cmd(mcsm_pkg::OP_STOP, 2, 65535, 131071));
		send(make_cmd(mcsm_pkg::OP_STOP_ALL, 0, 0, 0));
		send(make_cmd(mcsm_pkg::OP_PLAY, 0, 0, 131071));
		send(make_cmd(mcsm_pkg::OP_PLAY, 1, 65535, 65536));
		repeat (2) tick();
		begin
			mcsm_pkg::cmd_t c;
			c = make_cmd(mcsm_pkg::OP_TICK, 3, 65535, 131071);
			c.func = 4'd15;
			send(c);
		end
		send(make_cmd(mcsm_pkg::OP_STOP_ALL, 0, 0, 0));

		// phases across both sample formats
		write_mode(1);
		repeat (3) send(make_cmd(mcsm_pkg::OP_LOOP, $urandom_range(0, 3), 0, 3));
		send(make_cmd(mcsm_pkg::OP_PLAY, 3, 65535, 2));
		repeat (4) tick();
		random_items(200);
		write_mode(0);
		random_items(200);
		write_mode(1);
		random_items(200);
		write_mode(0);
		random_items(200);

		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#30ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
design/mcsm_pkg.sv
design/mcsm_if.sv
design/mcsm_ram.sv
design/mcsm_datapath.sv
design/mcsm_ctrl.sv
design/multichannel_clip_sequencer_mixer_core.sv
bench/mcsm_checker.sv
bench/tb.sv
